// ===== design/rrhq_pkg.sv =====
package rrhq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_CHECK  = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [1:0] KIND_OTHER = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  job_tag;
    logic [1:0]  req_kind;
    logic [31:0] handle_id;
    logic [31:0] handle_tag;
    logic        text_mode;
    logic        append_mode;
    logic [63:0] offset;
    logic [31:0] length;
  } req_t;

  typedef struct packed {
    logic may_proceed;
    logic job_found;
    logic queue_full;
  } rsp_t;

  // stored request body
  typedef struct packed {
    logic [7:0]  job;
    logic [1:0]  kind;
    logic [31:0] handle_id;
    logic [31:0] handle_tag;
    logic [1:0]  flags;
    logic [63:0] offset;
    logic [31:0] length;
  } entry_t;

  // control broadcast to every cell
  typedef struct packed {
    logic        load;      // write new entry at tail
    logic        shift;     // compact from sel upwards
    logic [IDX_W-1:0] sel;  // tail on insert, hit slot on remove
    logic [IDX_W-1:0] last; // slot that goes invalid on remove
  } cell_ctl_t;

endpackage

// ===== design/rrhq_cell.sv =====
module rrhq_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [rrhq_pkg::IDX_W-1:0] slot_i,
  input  rrhq_pkg::cell_ctl_t     ctl_i,
  input  rrhq_pkg::entry_t        new_i,
  input  rrhq_pkg::entry_t        next_i,
  input  logic                    next_vld_i,
  input  rrhq_pkg::entry_t        qry_i,
  input  logic                    enable_i,
  output rrhq_pkg::entry_t        ent_o,
  output logic                    vld_o,
  output logic                    block_o
);
  import rrhq_pkg::*;

  entry_t ent_q;
  logic   vld_q;
  logic   rw_a, rw_b, same_h, both_rd, ovl;
  logic [63:0] end_a, end_b;

  // hold, load from the port, or take the neighbour above
  always_ff @(posedge clk_i) begin
    if (ctl_i.load && slot_i == ctl_i.sel) begin
      ent_q <= new_i;
    end else if (ctl_i.shift && slot_i >= ctl_i.sel && next_vld_i) begin
      ent_q <= next_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ctl_i.load && slot_i == ctl_i.sel) begin
      vld_q <= 1'b1;
    end else if (ctl_i.shift && slot_i == ctl_i.last) begin
      vld_q <= 1'b0;
    end
  end

  // pairwise reorder test against the queried entry
  always_comb begin
    rw_a    = (qry_i.kind == KIND_READ) || (qry_i.kind == KIND_WRITE);
    rw_b    = (ent_q.kind == KIND_READ) || (ent_q.kind == KIND_WRITE);
    same_h  = (qry_i.handle_id == ent_q.handle_id) &&
              (qry_i.handle_tag == ent_q.handle_tag);
    both_rd = (qry_i.kind == KIND_READ) && (ent_q.kind == KIND_READ);
    end_a   = qry_i.offset + {32'd0, qry_i.length} - 64'd1;
    end_b   = ent_q.offset + {32'd0, ent_q.length} - 64'd1;
    ovl     = (qry_i.length != 32'd0) && (ent_q.length != 32'd0) &&
              (((end_a >= ent_q.offset) && (end_a <= end_b)) ||
               ((end_b >= qry_i.offset) && (end_b <= end_a)));
    if (!enable_i || !rw_a || !rw_b) begin
      block_o = 1'b1;
    end else if (!same_h) begin
      block_o = 1'b0;
    end else begin
      block_o = both_rd || (qry_i.flags != 2'd0) || ovl;
    end
  end

  assign ent_o = ent_q;
  assign vld_o = vld_q;

endmodule

// ===== design/request_reorder_hazard_queue.sv =====
// Request reorder hazard queue.
// Each operation does its lookup on the input beat, then its test/update.
// A new operation is accepted only after the previous one completes, since the
// registered newest-match search feeds the per-cell hazard test and compaction; a
// result held in the output register stalls the next input beat until it is taken.
// Reset: table empty, reorder_enable 1, result channel empty.
module request_reorder_hazard_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic           cfg_data_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  rrhq_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output rrhq_pkg::rsp_t out_data_o
);
  import rrhq_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;

  logic [1:0] st_q, st_d;
  logic       en_q;
  req_t       req_q;
  logic       hit_q;
  logic [IDX_W-1:0] hit_idx_q;
  logic [CNT_W-1:0] cnt_q;
  rsp_t       rsp_q;
  logic       out_vld_q;

  entry_t ent   [QUEUE_DEPTH];
  logic   vld   [QUEUE_DEPTH];
  logic   blk   [QUEUE_DEPTH];
  entry_t nxt   [QUEUE_DEPTH];
  logic   nxt_v [QUEUE_DEPTH];
  entry_t new_e, qry;
  cell_ctl_t ctl;
  logic   hit_d;
  logic [IDX_W-1:0] hit_idx_d;
  logic   any_blk;
  logic   full;
  logic   in_beat;

  assign full = (cnt_q == CNT_W'(QUEUE_DEPTH));

  // newest matching slot, done on the incoming beat
  always_comb begin
    hit_d = 1'b0;
    hit_idx_d = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (vld[i] && ent[i].job == in_data_i.job_tag) begin
        hit_d = 1'b1;
        hit_idx_d = IDX_W'(i);
      end
    end
  end

  // body for an insert; non read/write kinds store only the job tag, rest zeros
  always_comb begin
    new_e = '0;
    new_e.job = req_q.job_tag;
    if (req_q.req_kind == KIND_READ || req_q.req_kind == KIND_WRITE) begin
      new_e.kind       = req_q.req_kind;
      new_e.handle_id  = req_q.handle_id;
      new_e.handle_tag = req_q.handle_tag;
      new_e.flags      = {req_q.append_mode, req_q.text_mode};
      new_e.offset     = req_q.offset;
      new_e.length     = req_q.length;
    end
  end

  assign qry = ent[hit_idx_q];

  always_comb begin
    ctl = '0;
    if (st_q == ST_EXEC) begin
      case (req_q.opcode)
        OP_INSERT: begin
          ctl.load = !full;
          ctl.sel  = cnt_q[IDX_W-1:0];
        end
        OP_REMOVE: begin
          ctl.shift = hit_q;
          ctl.sel   = hit_idx_q;
          ctl.last  = IDX_W'(cnt_q - CNT_W'(1));
        end
        default: ;
      endcase
    end
  end

  // cell row
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    if (g + 1 < QUEUE_DEPTH) begin : g_nx
      assign nxt[g]   = ent[g+1];
      assign nxt_v[g] = vld[g+1];
    end else begin : g_top
      assign nxt[g]   = ent[g];
      assign nxt_v[g] = 1'b0;
    end
    rrhq_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .slot_i     (IDX_W'(g)),
      .ctl_i      (ctl),
      .new_i      (new_e),
      .next_i     (nxt[g]),
      .next_vld_i (nxt_v[g]),
      .qry_i      (qry),
      .enable_i   (en_q),
      .ent_o      (ent[g]),
      .vld_o      (vld[g]),
      .block_o    (blk[g])
    );
  end

  // any older entry that blocks
  always_comb begin
    any_blk = 1'b0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (IDX_W'(i) < hit_idx_q && blk[i]) any_blk = 1'b1;
    end
  end

  // input beat taken only in idle and when the result register is free by the next edge
  assign in_ready_o = (st_q == ST_IDLE) && (!out_vld_q || out_ready_i);
  assign in_beat    = in_valid_i && in_ready_o;

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: if (in_beat) st_d = ST_EXEC;
      ST_EXEC: st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      en_q      <= 1'b1;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (cfg_valid_i) en_q <= cfg_data_i;
      if (ctl.load) cnt_q <= cnt_q + CNT_W'(1);
      else if (ctl.shift) cnt_q <= cnt_q - CNT_W'(1);
      if (st_q == ST_EXEC) out_vld_q <= 1'b1;
      else if (out_ready_i) out_vld_q <= 1'b0;
    end
  end

  // beat capture and result
  always_ff @(posedge clk_i) begin
    if (st_q == ST_IDLE && in_beat) begin
      req_q     <= in_data_i;
      hit_q     <= hit_d;
      hit_idx_q <= hit_idx_d;
    end
    if (st_q == ST_EXEC) begin
      rsp_q <= '0;
      case (req_q.opcode)
        OP_INSERT: rsp_q.queue_full <= full;
        OP_CHECK: begin
          rsp_q.job_found   <= hit_q;
          rsp_q.may_proceed <= !hit_q || !any_blk;
        end
        OP_REMOVE: rsp_q.job_found <= hit_q;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = rsp_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(QUEUE_DEPTH)) else $error("count overflow");
  a_no_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl.load && ctl.shift)) else $error("load and shift together");
  a_out_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_EXEC) |=> out_valid_o) else $error("result missing");
  a_full_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.queue_full) |-> full) else $error("bad full flag");

endmodule
